/* hw/rtl/lpd_pkg.sv */
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

	// Field widths
	localparam int unsigned OP_W     = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD32_W = 32;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned HELD_W   = 8;
	localparam int unsigned HDR_W    = 56;  // header bytes 0..6 held; byte 7 arrives live
	localparam int unsigned HCNT_W   = 3;
	localparam int unsigned CFG_IDX_W = 1;

	// Register reset values
	localparam logic [WORD32_W-1:0] MAX_MSG_BYTES_RST = 32'd1048576;
	localparam logic [HELD_W-1:0]   MAX_HELD_MSGS_RST = 8'd16;

	// Keep-alive id and saturation limits
	localparam logic [WORD32_W-1:0] KA_ID        = 32'hffff_ffff;
	localparam logic [HELD_W-1:0]   HELD_CNT_MAX = 8'hff;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_MESSAGE_BYTES = 1'b0,
		CFG_MAX_HELD_MESSAGES = 1'b1
	} cfg_idx_t;

	// Operations carried by an input word
	typedef enum logic [OP_W-1:0] {
		OP_RX_BYTE  = 2'd0,
		OP_RELEASE  = 2'd1,
		OP_KA_SENT  = 2'd2,
		OP_RESTART  = 2'd3
	} op_t;

	// Result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_BYTE      = 3'd0,
		KIND_EMPTY     = 3'd1,
		KIND_KA_SEND   = 3'd2,
		KIND_KA_ANSWER = 3'd3,
		KIND_OVERSIZE  = 3'd4,
		KIND_TOO_MANY  = 3'd5,
		KIND_OVERFLOW  = 3'd6
	} kind_t;

	typedef struct packed {
		op_t                 operation;
		logic [BYTE_W-1:0]   rx_byte;
		logic [WORD32_W-1:0] release_bytes;
	} item_t;

	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   payload_byte;
		logic [WORD32_W-1:0] message_id;
		logic                last_of_message;
	} result_t;

	// Engine status seen by the top level
	typedef struct packed {
		logic              stopped;
		logic              in_payload;
		logic [HCNT_W-1:0] header_count;
	} status_t;

endpackage

/* hw/rtl/length_prefixed_message_deframer_core.sv */
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_core
// Deframes length-prefixed messages from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per handshake: an
//   operation with a received byte or a released message size. Output channel
//   (out_valid/out_ready) carries at most one result word per input word:
//   a payload byte with its message id and last mark, an empty message,
//   a keep-alive event, or an admission error.
//   An accepted word sits in the input register while the engine works on
//   it; its result is registered at the next edge and then offered.
//   Throughput: one word per cycle while the receiver takes results; the
//   frame state (header count, payload count, hold totals) is updated per word.
//   If the receiver stalls, the result register holds its word and the input
//   register holds at most one further word; in_ready then stays low until
//   the result is taken.
//   The user must write configuration (cfg_wr_en/cfg_index/cfg_data) only
//   while idle; the block does not enforce this. Reset clears all frame, hold
//   and error state and loads defaults (1 MiB message limit, 16 held messages).
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpd_pkg::WORD32_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpd_pkg::OP_W-1:0]      operation,
	input  logic [lpd_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [lpd_pkg::WORD32_W-1:0]  release_bytes,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpd_pkg::KIND_W-1:0]    kind,
	output logic [lpd_pkg::BYTE_W-1:0]    payload_byte,
	output logic [lpd_pkg::WORD32_W-1:0]  message_id,
	output logic                          last_of_message
);
	import lpd_pkg::*;

	item_t   in_item, item_s1;
	logic    valid_s1;
	logic    take;
	logic    slot_free;
	logic    res_valid;
	result_t res, out_res;
	status_t status;

	assign in_item = '{operation: op_t'(operation), rx_byte: rx_byte,
	                   release_bytes: release_bytes};

	// Process the registered word when the result register can take its result
	assign take = valid_s1 && slot_free;

	lpd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lpd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (take),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res),
		.status    (status)
	);

	lpd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind            = out_res.kind;
	assign payload_byte    = out_res.payload_byte;
	assign message_id      = out_res.message_id;
	assign last_of_message = out_res.last_of_message;

`ifndef ASSERT_OFF
	// A result never overwrites one the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && out_valid && !out_ready))
		else $error("result register overwritten");

	// Header assembly and payload counting never overlap
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.in_payload && status.header_count != '0))
		else $error("header count active during payload");

	// An admission error stops the block from the next cycle
	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.kind == KIND_OVERSIZE || res.kind == KIND_TOO_MANY
		               || res.kind == KIND_OVERFLOW)) |=> status.stopped)
		else $error("error result without stop");

	// Keep-alive results always carry the keep-alive id
	a_ka_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_KA_SEND || kind == KIND_KA_ANSWER))
		|-> message_id == KA_ID)
		else $error("keep-alive result with wrong id");
`endif

endmodule

/* hw/rtl/lpd_in_stage.sv */
// ----------------------------------------------------------------------------
// lpd_in_stage
// Input register: captures one word and offers it to the engine.
// ----------------------------------------------------------------------------
module lpd_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lpd_pkg::item_t in_item,
	input  logic           take,
	output logic           valid_s1,
	output lpd_pkg::item_t item_s1
);
	import lpd_pkg::*;

	logic valid_q;

	// Free when empty or when the held word moves on this cycle
	assign in_ready = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign valid_s1 = valid_q;

endmodule

/* hw/rtl/lpd_engine.sv */
// ----------------------------------------------------------------------------
// lpd_engine
// Frame state, admission checks and result generation; one word per cycle while advance is high.
// ----------------------------------------------------------------------------
module lpd_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpd_pkg::WORD32_W-1:0]  cfg_data,
	input  logic                          advance,
	input  lpd_pkg::item_t                item,
	output logic                          res_valid,
	output lpd_pkg::result_t              res,
	output lpd_pkg::status_t              status
);
	import lpd_pkg::*;

	// Configuration registers
	logic [WORD32_W-1:0] max_msg_bytes_q;
	logic [HELD_W-1:0]   max_held_q;

	// Frame and hold state
	logic [HDR_W-1:0]    header_shift_q, header_shift_d;
	logic [HCNT_W-1:0]   header_count_q, header_count_d;
	logic                in_payload_q,   in_payload_d;
	logic [WORD32_W-1:0] frame_length_q, frame_length_d;
	logic [WORD32_W-1:0] bytes_taken_q,  bytes_taken_d;
	logic [WORD32_W-1:0] frame_id_q,     frame_id_d;
	logic                awaiting_q,     awaiting_d;
	logic [HELD_W-1:0]   held_count_q,   held_count_d;
	logic [WORD32_W-1:0] held_total_q,   held_total_d;
	logic                stopped_q,      stopped_d;

	// Datapath helpers
	logic [63:0]         hdr_full;
	logic [WORD32_W-1:0] hdr_len, hdr_id;
	logic [WORD32_W-1:0] taken_inc;
	logic [WORD32_W-1:0] hold_len;
	logic [WORD32_W:0]   hold_sum;
	logic [WORD32_W-1:0] hold_total_sat;
	logic [HELD_W-1:0]   hold_count_inc;
	logic                over_limit;
	logic [5:0]          ins_shamt;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msg_bytes_q <= MAX_MSG_BYTES_RST;
			max_held_q      <= MAX_HELD_MSGS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_MESSAGE_BYTES: max_msg_bytes_q <= cfg_data;
				CFG_MAX_HELD_MESSAGES: max_held_q <= cfg_data[HELD_W-1:0];
				default: ;
			endcase
		end
	end

	// Header assembly: the eighth byte completes the header directly
	assign hdr_full  = {item.rx_byte, header_shift_q};
	assign hdr_len   = hdr_full[31:0];
	assign hdr_id    = hdr_full[63:32];
	assign ins_shamt = {header_count_q, 3'b000};

	// Payload progress
	assign taken_inc = bytes_taken_q + 32'd1;

	// Holding a completed message: payload length, or zero for an empty one
	assign hold_len       = in_payload_q ? frame_length_q : '0;
	assign hold_sum       = {1'b0, held_total_q} + {1'b0, hold_len};
	assign hold_total_sat = hold_sum[WORD32_W] ? '1 : hold_sum[WORD32_W-1:0];
	assign hold_count_inc = (held_count_q == HELD_CNT_MAX) ? held_count_q
	                                                       : held_count_q + 8'd1;

	// Overflow check without wrap
	assign over_limit = ({1'b0, hdr_len} + {1'b0, held_total_q}) > {1'b0, max_msg_bytes_q};

	// Next state and result
	always_comb begin
		header_shift_d = header_shift_q;
		header_count_d = header_count_q;
		in_payload_d   = in_payload_q;
		frame_length_d = frame_length_q;
		bytes_taken_d  = bytes_taken_q;
		frame_id_d     = frame_id_q;
		awaiting_d     = awaiting_q;
		held_count_d   = held_count_q;
		held_total_d   = held_total_q;
		stopped_d      = stopped_q;
		res_valid      = 1'b0;
		res            = '{kind: KIND_BYTE, payload_byte: '0, message_id: '0,
		                   last_of_message: 1'b0};

		if (advance) begin
			unique case (item.operation)
				OP_RX_BYTE: begin
					if (!stopped_q && in_payload_q) begin
						res_valid        = 1'b1;
						res.payload_byte = item.rx_byte;
						res.message_id   = frame_id_q;
						if (taken_inc >= frame_length_q) begin
							res.last_of_message = 1'b1;
							held_total_d   = hold_total_sat;
							held_count_d   = hold_count_inc;
							in_payload_d   = 1'b0;
							frame_length_d = '0;
							bytes_taken_d  = '0;
						end else begin
							bytes_taken_d = taken_inc;
						end
					end else if (!stopped_q) begin
						if (header_count_q != 3'd7) begin
							header_shift_d = header_shift_q
							               | (HDR_W'(item.rx_byte) << ins_shamt);
							header_count_d = header_count_q + 3'd1;
						end else begin
							header_shift_d = '0;
							header_count_d = '0;
							frame_id_d     = hdr_id;
							frame_length_d = hdr_len;
							res_valid      = 1'b1;
							res.message_id = hdr_id;
							if (hdr_len == '0 && hdr_id == KA_ID) begin
								// Keep-alive: answer a request or end our wait
								res.kind   = awaiting_q ? KIND_KA_ANSWER : KIND_KA_SEND;
								awaiting_d = 1'b0;
							end else if (hdr_len > max_msg_bytes_q) begin
								res.kind       = KIND_OVERSIZE;
								frame_length_d = '0;
								stopped_d      = 1'b1;
							end else if (held_count_q >= max_held_q) begin
								res.kind       = KIND_TOO_MANY;
								frame_length_d = '0;
								stopped_d      = 1'b1;
							end else if (over_limit) begin
								res.kind       = KIND_OVERFLOW;
								frame_length_d = '0;
								stopped_d      = 1'b1;
							end else if (hdr_len == '0) begin
								// Empty message counts as held with zero bytes
								res.kind            = KIND_EMPTY;
								res.last_of_message = 1'b1;
								held_count_d        = hold_count_inc;
							end else begin
								res_valid     = 1'b0;
								in_payload_d  = 1'b1;
								bytes_taken_d = '0;
							end
						end
					end
				end
				OP_RELEASE: begin
					if (held_count_q != '0) begin
						held_count_d = held_count_q - 8'd1;
					end
					held_total_d = (held_total_q > item.release_bytes)
					             ? held_total_q - item.release_bytes : '0;
				end
				OP_KA_SENT: begin
					if (!stopped_q) begin
						awaiting_d = 1'b1;
					end
				end
				OP_RESTART: begin
					header_shift_d = '0;
					header_count_d = '0;
					in_payload_d   = 1'b0;
					frame_length_d = '0;
					bytes_taken_d  = '0;
					stopped_d      = 1'b0;
					awaiting_d     = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_shift_q <= '0;
			header_count_q <= '0;
			in_payload_q   <= 1'b0;
			frame_length_q <= '0;
			bytes_taken_q  <= '0;
			frame_id_q     <= '0;
			awaiting_q     <= 1'b0;
			held_count_q   <= '0;
			held_total_q   <= '0;
			stopped_q      <= 1'b0;
		end else begin
			header_shift_q <= header_shift_d;
			header_count_q <= header_count_d;
			in_payload_q   <= in_payload_d;
			frame_length_q <= frame_length_d;
			bytes_taken_q  <= bytes_taken_d;
			frame_id_q     <= frame_id_d;
			awaiting_q     <= awaiting_d;
			held_count_q   <= held_count_d;
			held_total_q   <= held_total_d;
			stopped_q      <= stopped_d;
		end
	end

	assign status = '{stopped: stopped_q, in_payload: in_payload_q,
	                  header_count: header_count_q};

endmodule

/* hw/rtl/lpd_out_stage.sv */
// ----------------------------------------------------------------------------
// lpd_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module lpd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  lpd_pkg::result_t res,
	output logic             slot_free,
	output logic             out_valid,
	input  logic             out_ready,
	output lpd_pkg::result_t out_res
);
	import lpd_pkg::*;

	logic    valid_q;
	result_t res_q;

	// A new result may land when empty or when the held one leaves now
	assign slot_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
